// File: design/srs_pkg.sv
// Package for the scrypt ROMix core: sizes, constants and Salsa20 helpers.
// No dependencies; srs_if and the top level import it.
package srs_pkg;
  localparam int BlockR = 1;
  localparam int MaxCostLog2 = 10;
  localparam int BlkWords = 32 * BlockR;
  localparam int Items = 16 * BlockR;
  localparam int BlkPairs = 16 * BlockR;
  localparam int PairAw = $clog2(BlkPairs);
  localparam int ItemAw = $clog2(Items + 1);
  localparam int TabAw = $clog2(BlkPairs) + MaxCostLog2;
  localparam int IdxW = MaxCostLog2;
  localparam int SubW = $clog2(2 * BlockR + 1);

  typedef logic [31:0] word_t;
  typedef word_t [15:0] sblk_t;

  function automatic word_t rotl(word_t v, int s);
    rotl = (v << s) | (v >> (32 - s));
  endfunction

  // One Salsa double round.
  function automatic sblk_t dround(sblk_t x);
    sblk_t w;
    w = x;
    w[4] ^= rotl(w[0] + w[12], 7);  w[8] ^= rotl(w[4] + w[0], 9);
    w[12] ^= rotl(w[8] + w[4], 13); w[0] ^= rotl(w[12] + w[8], 18);
    w[9] ^= rotl(w[5] + w[1], 7);   w[13] ^= rotl(w[9] + w[5], 9);
    w[1] ^= rotl(w[13] + w[9], 13); w[5] ^= rotl(w[1] + w[13], 18);
    w[14] ^= rotl(w[10] + w[6], 7); w[2] ^= rotl(w[14] + w[10], 9);
    w[6] ^= rotl(w[2] + w[14], 13); w[10] ^= rotl(w[6] + w[2], 18);
    w[3] ^= rotl(w[15] + w[11], 7); w[7] ^= rotl(w[3] + w[15], 9);
    w[11] ^= rotl(w[7] + w[3], 13); w[15] ^= rotl(w[11] + w[7], 18);
    w[1] ^= rotl(w[0] + w[3], 7);   w[2] ^= rotl(w[1] + w[0], 9);
    w[3] ^= rotl(w[2] + w[1], 13);  w[0] ^= rotl(w[3] + w[2], 18);
    w[6] ^= rotl(w[5] + w[4], 7);   w[7] ^= rotl(w[6] + w[5], 9);
    w[4] ^= rotl(w[7] + w[6], 13);  w[5] ^= rotl(w[4] + w[7], 18);
    w[11] ^= rotl(w[10] + w[9], 7); w[8] ^= rotl(w[11] + w[10], 9);
    w[9] ^= rotl(w[8] + w[11], 13); w[10] ^= rotl(w[9] + w[8], 18);
    w[12] ^= rotl(w[15] + w[14], 7); w[13] ^= rotl(w[12] + w[15], 9);
    w[14] ^= rotl(w[13] + w[12], 13); w[15] ^= rotl(w[14] + w[13], 18);
    dround = w;
  endfunction

  typedef enum logic [6:0] {
    ST_LOAD = 7'b0000001, ST_XRD = 7'b0000010, ST_MIX = 7'b0000100,
    ST_ADD = 7'b0001000, ST_WB = 7'b0010000, ST_OUT = 7'b0100000,
    ST_SRD = 7'b1000000
  } state_t;
endpackage

// File: design/srs_if.sv
// Valid/ready channel interfaces for the scrypt ROMix core.
// Depends on srs_pkg.
interface srs_in_if import srs_pkg::*; ();
  logic valid;
  logic ready;
  logic [63:0] in_word;
  modport source(output valid, output in_word, input ready);
  modport sink(input valid, input in_word, output ready);
endinterface

interface srs_out_if import srs_pkg::*; ();
  logic valid;
  logic ready;
  logic [63:0] out_word;
  logic last_word;
  modport source(output valid, output out_word, output last_word, input ready);
  modport sink(input valid, input out_word, input last_word, output ready);
endinterface

interface srs_cfg_if import srs_pkg::*; ();
  logic valid;
  logic ready;
  logic [3:0] cost_log2;
  modport source(output valid, output cost_log2, input ready);
  modport sink(input valid, input cost_log2, output ready);
endinterface

// File: design/srs_ram.sv
// Generic single-port synchronous RAM with registered read data.
// No dependencies.
module srs_ram #(
  parameter int Aw = 4,
  parameter int Dw = 64
) (
  input  logic          clk,
  input  logic          we,
  input  logic [Aw-1:0] addr,
  input  logic [Dw-1:0] wdata,
  output logic [Dw-1:0] rdata
);
  logic [Dw-1:0] mem [2**Aw];
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

// File: design/scrypt_romix_salsa_core_top.sv
// Top level of the scrypt ROMix (Salsa20/8 BlockMix) core.
// Depends on srs_pkg, srs_if and srs_ram.
// Operation: 16*r load transactions, then 2N BlockMix rounds: a fetch of the last
// sub-block, then per sub-block X (and V[j]) streamed in, Salsa20/8 (one double
// round a cycle), an add and a write-back. One block at a time; each output pair is
// read from the store before it is shown and is held while out_ch.ready is low.
// Reset (rst_n low, synchronous) clears control and sets cost_log2 to 10; memories
// keep content.
module scrypt_romix_salsa_core_top import srs_pkg::*; (
  input logic   clk,
  input logic   rst_n,
  srs_in_if.sink    in_ch,
  srs_out_if.source out_ch,
  srs_cfg_if.sink   cfg_ch
);
  state_t state_r;
  logic [3:0] cost_r;
  logic [IdxW-1:0] n_mask_r;   // N-1 latched at block start
  logic [IdxW:0] iter_r;       // ROMix round counter within a phase
  logic phase2_r;
  logic [SubW-1:0] sub_r;      // sub-block in BlockMix
  logic [4:0] cnt_r;           // pair counter within a sub-block step
  logic [ItemAw-1:0] load_r;
  sblk_t cur_r, tmp_r, src_r;  // chaining value, Salsa state, Salsa input
  logic [2:0] rnd_r;
  word_t integ_r;

  // X and Y stores hold blocks as word pairs and swap roles after each BlockMix.
  logic x_we, y_we, v_we;
  logic [PairAw-1:0] x_a, y_a;
  logic [63:0] x_wd, x_rd, y_wd, y_rd, v_rd;
  logic [TabAw-1:0] v_a;
  logic ysel_r; // which of X/Y stores is the current block
  logic [63:0] x_rdc; // current block read data

  srs_ram #(.Aw(PairAw), .Dw(64)) u_x (.clk, .we(x_we), .addr(x_a), .wdata(x_wd),
    .rdata(x_rd));
  srs_ram #(.Aw(PairAw), .Dw(64)) u_y (.clk, .we(y_we), .addr(y_a), .wdata(y_wd),
    .rdata(y_rd));
  srs_ram #(.Aw(TabAw), .Dw(64)) u_v (.clk, .we(v_we), .addr(v_a), .wdata(x_rdc),
    .rdata(v_rd));

  assign x_rdc = ysel_r ? y_rd : x_rd;

  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) cost_r <= 4'd10;
    else if (cfg_ch.valid) cost_r <= cfg_ch.cost_log2;
  end

  assign in_ch.ready = (state_r == ST_LOAD);
  // Read pipeline: address issued at cnt; data present at cnt belongs to pair cnt-1.
  logic [PairAw-1:0] rd_pair, wr_pair, ybase, srd_pair;
  logic [4:0] cm1;
  assign cm1 = cnt_r - 5'd1;
  assign rd_pair = PairAw'(sub_r * 8) + PairAw'(cnt_r[2:0]);
  assign wr_pair = PairAw'(cm1[2:0]);
  // Pairs of the last sub-block, which seeds the BlockMix chaining value.
  assign srd_pair = PairAw'((2 * BlockR - 1) * 8) + PairAw'(cnt_r[2:0]);
  // Destination of sub-block i: even to first half, odd to second half.
  assign ybase = PairAw'((sub_r >> 1) * 8 + (sub_r & 1) * 8 * BlockR);
  logic [IdxW-1:0] jidx;
  assign jidx = IdxW'(integ_r) & n_mask_r;

  always_comb begin
    x_we = 1'b0; y_we = 1'b0; v_we = 1'b0;
    x_a = rd_pair; y_a = rd_pair; x_wd = in_ch.in_word; y_wd = in_ch.in_word;
    v_a = {IdxW'(iter_r), rd_pair};
    unique case (state_r)
      ST_LOAD: begin
        x_a = PairAw'(load_r);
        x_we = in_ch.valid;
      end
      ST_SRD: begin
        x_a = srd_pair;
        y_a = x_a;
        v_a = {jidx, srd_pair};
      end
      ST_XRD: begin
        // Phase one copies X to V[i]; phase two reads V[j].
        v_a = phase2_r ? {jidx, rd_pair} : {iter_r[IdxW-1:0], wr_pair};
        v_we = !phase2_r && cnt_r != 5'd0;
        if (!phase2_r) v_a = {iter_r[IdxW-1:0], PairAw'(sub_r*8) + wr_pair};
        else v_a = {jidx, rd_pair};
      end
      ST_WB: begin
        x_a = ybase + wr_pair; y_a = x_a;
        x_wd = {cur_r[2*wr_pair[2:0]+1], cur_r[2*wr_pair[2:0]]};
        y_wd = x_wd;
        x_we = ysel_r && cnt_r != 5'd0;
        y_we = !ysel_r && cnt_r != 5'd0;
      end
      ST_OUT: begin
        x_a = PairAw'(load_r); y_a = x_a;
      end
      default: ;
    endcase
  end

  logic out_v_r, out_l_r;
  logic [63:0] out_d_r;
  logic out_load;
  assign out_ch.valid = out_v_r;
  assign out_ch.out_word = out_d_r;
  assign out_ch.last_word = out_l_r;
  // A fetched pair moves into the output register once that register is free.
  assign out_load = (state_r == ST_OUT) && (cnt_r != 5'd0) && (!out_v_r || out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) out_v_r <= 1'b0;
    else if (out_load) out_v_r <= 1'b1;
    else if (out_ch.ready) out_v_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD; load_r <= '0; cnt_r <= '0; sub_r <= '0; iter_r <= '0;
      phase2_r <= 1'b0; ysel_r <= 1'b0; rnd_r <= '0;
    end else begin
      unique case (state_r)
        ST_LOAD: if (in_ch.valid) begin
          if (load_r == ItemAw'(Items - 1)) begin
            load_r <= '0; state_r <= ST_SRD; iter_r <= '0; phase2_r <= 1'b0;
            ysel_r <= 1'b0;
            n_mask_r <= IdxW'((1 << ((cost_r > MaxCostLog2) ? MaxCostLog2 : cost_r)) - 1);
          end else load_r <= load_r + 1'b1;
        end
        ST_SRD: begin
          // Fetch last sub-block (xor V[j] in phase two) into cur: collect 8 pairs.
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r != 0) begin
            cur_r[2*cm1[2:0]] <= x_rdc[31:0] ^ (phase2_r ? v_rd[31:0] : 32'd0);
            cur_r[2*cm1[2:0]+1] <= x_rdc[63:32] ^ (phase2_r ? v_rd[63:32] : 32'd0);
          end
          if (cnt_r == 5'd8) begin cnt_r <= '0; sub_r <= '0; state_r <= ST_XRD; end
        end
        ST_XRD: begin
          // Stream sub-block i of X (and V[j]) into the Salsa input.
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r != 0) begin
            tmp_r[2*cm1[2:0]] <= cur_r[2*cm1[2:0]] ^ x_rdc[31:0]
              ^ (phase2_r ? v_rd[31:0] : 32'd0);
            tmp_r[2*cm1[2:0]+1] <= cur_r[2*cm1[2:0]+1] ^ x_rdc[63:32]
              ^ (phase2_r ? v_rd[63:32] : 32'd0);
          end
          if (cnt_r == 5'd8) begin cnt_r <= '0; state_r <= ST_MIX; rnd_r <= '0; end
        end
        ST_MIX: begin
          if (rnd_r == 3'd0) src_r <= tmp_r;
          tmp_r <= dround(tmp_r);
          rnd_r <= rnd_r + 1'b1;
          if (rnd_r == 3'd3) state_r <= ST_ADD;
        end
        ST_ADD: begin
          for (int k = 0; k < 16; k++) cur_r[k] <= src_r[k] + tmp_r[k];
          // Word 0 of the last sub-block result is Integerify of the next X.
          if (sub_r == SubW'(2*BlockR-1)) integ_r <= src_r[0] + tmp_r[0];
          state_r <= ST_WB;
        end
        ST_WB: begin
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == 5'd8) begin
            cnt_r <= '0;
            if (sub_r == SubW'(2*BlockR-1)) begin
              sub_r <= '0; ysel_r <= !ysel_r;
              if (iter_r[IdxW-1:0] == n_mask_r) begin
                iter_r <= '0;
                if (phase2_r) begin state_r <= ST_OUT; load_r <= '0; end
                else begin phase2_r <= 1'b1; state_r <= ST_SRD; end
              end else begin iter_r <= iter_r + 1'b1; state_r <= ST_SRD; end
            end else begin sub_r <= sub_r + 1'b1; state_r <= ST_XRD; end
          end
        end
        ST_OUT: begin
          // load_r issues reads; a pending pair is shown when the slot is free.
          if (cnt_r == 5'd0) begin
            cnt_r <= 5'd1;
          end else if (out_load) begin
            out_d_r <= x_rdc;
            out_l_r <= (load_r == ItemAw'(Items - 1));
            cnt_r <= '0;
            if (load_r == ItemAw'(Items - 1)) begin load_r <= '0; state_r <= ST_LOAD; end
            else load_r <= load_r + 1'b1;
          end
        end
        default: state_r <= ST_LOAD;
      endcase
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && !out_ch.ready |=> out_v_r && $stable(out_d_r))
    else $error("result dropped while stalled");
  a_no_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != ST_LOAD |-> !in_ch.ready)
    else $error("input taken while computing");
  a_mix_len: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_MIX && rnd_r == 3'd3 |=> state_r == ST_ADD)
    else $error("salsa round count wrong");
endmodule
